FILE: hw/rtl/nru_pkg.sv
// ----------------------------------------------------------------------------
// NRU package
// Shared types and constants for the not-recently-used page replacement block.
// ----------------------------------------------------------------------------
`default_nettype none

package nru_pkg;

	localparam int FRAMES_DEFAULT = 16;
	localparam int PAGE_BITS = 16;
	localparam int FIU_W = 5;
	localparam int PERIOD_W = 8;
	localparam int TOTAL_W = 32;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 8;

	localparam logic [FIU_W-1:0] FIU_RESET = 5'd16;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd10;

	localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_IN_USE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_PERIOD = 1'd1;

	typedef struct packed {
		logic [PAGE_BITS-1:0] page_number;
		logic dirty;
	} ref_t;

	typedef struct packed {
		logic hit;
		logic victim_valid;
		logic [PAGE_BITS-1:0] victim_page;
		logic [TOTAL_W-1:0] hit_total;
		logic [TOTAL_W-1:0] fault_total;
	} res_t;

	typedef struct packed {
		logic match;
		logic free;
		logic better;
		logic above;
	} scan_flags_t;

endpackage

`default_nettype wire

FILE: hw/rtl/nru_scan_unit.sv
// ----------------------------------------------------------------------------
// NRU scan unit
// Compares one frame entry per cycle against the looked-up page, the current
// best victim candidate and the rank being removed from the age order.
// ----------------------------------------------------------------------------
`default_nettype none

module nru_scan_unit
	import nru_pkg::*;
#(
	parameter int RANK_W = 4
) (
	input  wire logic                 entry_valid,
	input  wire logic [PAGE_BITS-1:0] entry_page,
	input  wire logic [1:0]           entry_class,
	input  wire logic [RANK_W-1:0]    entry_rank,
	input  wire logic [PAGE_BITS-1:0] key_page,
	input  wire logic                 best_found,
	input  wire logic [1:0]           best_class,
	input  wire logic [RANK_W-1:0]    best_rank,
	input  wire logic [RANK_W-1:0]    drop_rank,
	output scan_flags_t               flags
);

	always_comb begin
		flags.match = entry_valid && (entry_page == key_page);
		flags.free = !entry_valid;
		flags.better = entry_valid && (!best_found || (entry_class < best_class) ||
			((entry_class == best_class) && (entry_rank < best_rank)));
		flags.above = entry_valid && (entry_rank > drop_rank);
	end

endmodule

`default_nettype wire

FILE: hw/rtl/nru_page_replacement.sv
// ----------------------------------------------------------------------------
// NRU page replacement
// Not-recently-used page replacement over a small pool of frames.
// ----------------------------------------------------------------------------
// Each reference is handled by a sequencer that walks the frame table one
// entry per cycle through a single compare unit. A reference passes through
// a transfer, a lookup walk and a commit. A miss with a free frame, while
// fewer frames are resident than the frames-in-use limit, walks all FRAMES
// entries. A hit ends the lookup at the matching frame and adds a walk over
// all FRAMES entries that closes the gap in the age order. A miss with no
// free frame, or at the frames-in-use limit, adds a victim walk and that
// same age walk. The result sits in an output register, so the next reference
// is taken while it waits for its transfer; a commit waits only while the
// previous result is still held by the receiver.
`default_nettype none

module nru_page_replacement
	import nru_pkg::*;
#(
	parameter int FRAMES = FRAMES_DEFAULT
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  ref_valid,
	output logic                       ref_stall,
	input  wire ref_t                  ref_data,
	output logic                       res_valid,
	input  wire logic                  res_stall,
	output res_t                       res_data,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int RC_W = $clog2(FRAMES + 1);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_LOOKUP = 5'b00010,
		S_VSCAN  = 5'b00100,
		S_DROP   = 5'b01000,
		S_WRITE  = 5'b10000
	} state_t;

	state_t state_q;

	logic [FRAMES-1:0]    entry_valid_q;
	logic [PAGE_BITS-1:0] entry_page_q [FRAMES];
	logic [1:0]           entry_class_q [FRAMES];
	logic [IDX_W-1:0]     entry_rank_q [FRAMES];

	logic [FIU_W-1:0]     fiu_q;
	logic [PERIOD_W-1:0]  clear_period_q;
	logic [PERIOD_W-1:0]  period_q;
	logic [RC_W-1:0]      resident_q;
	logic [TOTAL_W-1:0]   hits_q;
	logic [TOTAL_W-1:0]   faults_q;

	logic [IDX_W-1:0]     idx_q;
	logic [PAGE_BITS-1:0] page_q;
	logic                 dirty_q;
	logic                 hit_q;
	logic                 hit_mod_q;
	logic                 evict_q;
	logic [IDX_W-1:0]     slot_q;
	logic                 free_found_q;
	logic [IDX_W-1:0]     free_slot_q;
	logic                 best_found_q;
	logic [IDX_W-1:0]     best_slot_q;
	logic [1:0]           best_class_q;
	logic [IDX_W-1:0]     best_rank_q;
	logic [PAGE_BITS-1:0] best_page_q;
	logic [IDX_W-1:0]     tgt_rank_q;

	logic                 res_valid_q;
	res_t                 res_q;

	scan_flags_t          flags;
	logic                 ref_xfer;
	logic                 last_idx;
	logic                 commit;
	logic [RC_W-1:0]      cap;
	logic [PERIOD_W-1:0]  period_eff;
	logic [PERIOD_W:0]    period_inc;
	logic [PERIOD_W-1:0]  period_next;
	logic                 cur_free_found;
	logic [IDX_W-1:0]     cur_free_slot;
	logic [TOTAL_W-1:0]   hits_next;
	logic [TOTAL_W-1:0]   faults_next;
	logic [IDX_W-1:0]     rank_top;

	nru_scan_unit #(
		.RANK_W(IDX_W)
	) u_scan (
		.entry_valid(entry_valid_q[idx_q]),
		.entry_page (entry_page_q[idx_q]),
		.entry_class(entry_class_q[idx_q]),
		.entry_rank (entry_rank_q[idx_q]),
		.key_page   (page_q),
		.best_found (best_found_q),
		.best_class (best_class_q),
		.best_rank  (best_rank_q),
		.drop_rank  (tgt_rank_q),
		.flags      (flags)
	);

	assign ref_stall = (state_q != S_IDLE);
	assign ref_xfer = ref_valid && !ref_stall;
	assign res_valid = res_valid_q;
	assign res_data = res_q;
	assign last_idx = (idx_q == IDX_W'(FRAMES - 1));
	assign commit = (state_q == S_WRITE) && (!res_valid_q || !res_stall);
	assign rank_top = IDX_W'(resident_q - RC_W'(1));

	always_comb begin
		if (fiu_q == '0) begin
			cap = RC_W'(1);
		end else if (int'(fiu_q) > FRAMES) begin
			cap = RC_W'(FRAMES);
		end else begin
			cap = RC_W'(fiu_q);
		end
		period_eff = (clear_period_q == '0) ? PERIOD_W'(1) : clear_period_q;
		period_inc = {1'b0, period_q} + (PERIOD_W + 1)'(1);
		period_next = (period_inc >= {1'b0, period_eff}) ? '0 : period_inc[PERIOD_W-1:0];
		cur_free_found = free_found_q || flags.free;
		cur_free_slot = free_found_q ? free_slot_q : idx_q;
		hits_next = (hits_q == '1) ? hits_q : hits_q + TOTAL_W'(1);
		faults_next = (faults_q == '1) ? faults_q : faults_q + TOTAL_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fiu_q <= FIU_RESET;
			clear_period_q <= PERIOD_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FRAMES_IN_USE: fiu_q <= cfg_data[FIU_W-1:0];
				CFG_CLEAR_PERIOD: clear_period_q <= cfg_data[PERIOD_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= '0;
			period_q <= '0;
			resident_q <= '0;
			hits_q <= '0;
			faults_q <= '0;
			entry_valid_q <= '0;
			hit_q <= 1'b0;
			evict_q <= 1'b0;
			free_found_q <= 1'b0;
			best_found_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && !res_stall && !commit) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (ref_xfer) begin
						period_q <= period_next;
						idx_q <= '0;
						hit_q <= 1'b0;
						evict_q <= 1'b0;
						free_found_q <= 1'b0;
						best_found_q <= 1'b0;
						state_q <= S_LOOKUP;
					end
				end
				S_LOOKUP: begin
					if (flags.match) begin
						hit_q <= 1'b1;
						idx_q <= '0;
						state_q <= S_DROP;
					end else begin
						if (flags.free && !free_found_q) begin
							free_found_q <= 1'b1;
						end
						if (last_idx) begin
							idx_q <= '0;
							if ((resident_q < cap) && cur_free_found) begin
								state_q <= S_WRITE;
							end else begin
								state_q <= S_VSCAN;
							end
						end else begin
							idx_q <= idx_q + IDX_W'(1);
						end
					end
				end
				S_VSCAN: begin
					if (flags.better) begin
						best_found_q <= 1'b1;
					end
					if (last_idx) begin
						idx_q <= '0;
						if (best_found_q || flags.better) begin
							evict_q <= 1'b1;
							state_q <= S_DROP;
						end else begin
							state_q <= S_WRITE;
						end
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				S_DROP: begin
					if (last_idx) begin
						idx_q <= '0;
						state_q <= S_WRITE;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				S_WRITE: begin
					if (commit) begin
						res_valid_q <= 1'b1;
						state_q <= S_IDLE;
						if (hit_q) begin
							hits_q <= hits_next;
						end else begin
							faults_q <= faults_next;
							entry_valid_q[slot_q] <= 1'b1;
							if (!evict_q) begin
								resident_q <= resident_q + RC_W'(1);
							end
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (ref_xfer) begin
					page_q <= ref_data.page_number;
					dirty_q <= ref_data.dirty;
					if (period_q == '0) begin
						for (int i = 0; i < FRAMES; i++) begin
							if (entry_valid_q[i]) begin
								entry_class_q[i][1] <= 1'b0;
							end
						end
					end
				end
			end
			S_LOOKUP: begin
				if (flags.match) begin
					slot_q <= idx_q;
					tgt_rank_q <= entry_rank_q[idx_q];
					hit_mod_q <= entry_class_q[idx_q][0];
				end else begin
					if (flags.free && !free_found_q) begin
						free_slot_q <= idx_q;
					end
					if (last_idx) begin
						slot_q <= cur_free_slot;
					end
				end
			end
			S_VSCAN: begin
				if (flags.better) begin
					best_slot_q <= idx_q;
					best_class_q <= entry_class_q[idx_q];
					best_rank_q <= entry_rank_q[idx_q];
					best_page_q <= entry_page_q[idx_q];
				end
				if (last_idx) begin
					if (flags.better) begin
						slot_q <= idx_q;
						tgt_rank_q <= entry_rank_q[idx_q];
					end else if (best_found_q) begin
						slot_q <= best_slot_q;
						tgt_rank_q <= best_rank_q;
					end else begin
						slot_q <= free_slot_q;
					end
				end
			end
			S_DROP: begin
				if (flags.above && (idx_q != slot_q)) begin
					entry_rank_q[idx_q] <= entry_rank_q[idx_q] - IDX_W'(1);
				end
			end
			S_WRITE: begin
				if (commit) begin
					res_q.hit <= hit_q;
					res_q.victim_valid <= evict_q;
					res_q.victim_page <= evict_q ? best_page_q : '0;
					res_q.hit_total <= hit_q ? hits_next : hits_q;
					res_q.fault_total <= hit_q ? faults_q : faults_next;
					if (hit_q) begin
						entry_class_q[slot_q] <= {1'b1, hit_mod_q | dirty_q};
						entry_rank_q[slot_q] <= rank_top;
					end else begin
						entry_page_q[slot_q] <= page_q;
						entry_class_q[slot_q] <= {1'b1, dirty_q};
						entry_rank_q[slot_q] <= evict_q ? rank_top : IDX_W'(resident_q);
					end
				end
			end
			default: ;
		endcase
	end

	a_resident_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(entry_valid_q) == int'(resident_q))
		else $error("resident count disagrees with valid frames");

	a_hit_no_victim: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.hit |-> !res_q.victim_valid)
		else $error("hit reported together with an eviction");

	a_victim_page_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_q.victim_valid |-> res_q.victim_page == '0)
		else $error("victim page nonzero without an eviction");

	a_drop_reason: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DROP |-> (hit_q || evict_q))
		else $error("age walk entered without a hit or an eviction");

	a_resident_cap: assert property (@(posedge clk) disable iff (!arst_n)
		int'(resident_q) <= FRAMES)
		else $error("resident count exceeds frame pool");

endmodule

`default_nettype wire
